>>> sv/wsd_pkg.sv
// Shared types and constants for the websocket frame deframer.
// No dependencies; every other file of the block uses this package.
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR1     = 3'd0,
        PH_HDR2     = 3'd1,
        PH_HDR2_BAD = 3'd2,
        PH_EXTLEN   = 3'd3,
        PH_MASK     = 3'd4,
        PH_PAYLOAD  = 3'd5,
        PH_HALT     = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_PONG  = 2'd1,
        KIND_CLOSE = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    localparam logic [3:0] OP_CLOSE      = 4'h8;
    localparam logic [3:0] OP_PING       = 4'h9;
    localparam logic [6:0] LEN7_MAX      = 7'd125;
    localparam logic [6:0] LEN7_EXT16    = 7'd126;
    localparam logic [2:0] EXT16_COUNT   = 3'd1;
    localparam logic [2:0] EXT64_COUNT   = 3'd7;
    localparam logic [2:0] MASK_KEY_BYTES = 3'd4;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
    } t_result;

endpackage

>>> sv/wsd_parser.sv
// Frame parser state and the per-byte update logic of the deframer.
// Depends on wsd_pkg for phase, kind and result types.
module wsd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_restart,
    output logic             o_res_valid,
    output wsd_pkg::t_result o_res
);

    wsd_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_count, n_count;
    logic            r_fin, n_fin;
    logic [3:0]      r_opcode, n_opcode;
    logic [63:0]     r_remain, n_remain;
    logic [31:0]     r_key, n_key;
    logic [1:0]      r_pos, n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsd_pkg::PH_HDR1;
            r_count  <= '0;
            r_fin    <= 1'b0;
            r_opcode <= '0;
            r_remain <= '0;
            r_key    <= '0;
            r_pos    <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_fin    <= n_fin;
            r_opcode <= n_opcode;
            r_remain <= n_remain;
            r_key    <= n_key;
            r_pos    <= n_pos;
        end
    end

    always_comb begin
        wsd_pkg::t_phase e_phase;
        logic [2:0]      e_count;
        logic            e_fin;
        logic [3:0]      e_opcode;
        logic [63:0]     e_remain;
        logic [31:0]     e_key;
        logic [1:0]      e_pos;
        logic [7:0]      key_byte;
        logic [2:0]      cnt_inc;
        logic            control;
        logic            finish;

        // Restart takes effect before the byte of the same beat.
        e_phase  = i_restart ? wsd_pkg::PH_HDR1 : r_phase;
        e_count  = i_restart ? 3'd0 : r_count;
        e_fin    = i_restart ? 1'b0 : r_fin;
        e_opcode = i_restart ? 4'd0 : r_opcode;
        e_remain = i_restart ? 64'd0 : r_remain;
        e_key    = i_restart ? 32'd0 : r_key;
        e_pos    = i_restart ? 2'd0 : r_pos;

        n_phase  = e_phase;
        n_count  = e_count;
        n_fin    = e_fin;
        n_opcode = e_opcode;
        n_remain = e_remain;
        n_key    = e_key;
        n_pos    = e_pos;

        case (e_pos)
            2'd0:    key_byte = e_key[31:24];
            2'd1:    key_byte = e_key[23:16];
            2'd2:    key_byte = e_key[15:8];
            default: key_byte = e_key[7:0];
        endcase
        cnt_inc = e_count + 3'd1;
        control = (e_opcode == wsd_pkg::OP_CLOSE) || (e_opcode == wsd_pkg::OP_PING);
        finish  = 1'b0;

        o_res_valid    = 1'b0;
        o_res.kind     = wsd_pkg::KIND_DATA;
        o_res.payload  = 8'd0;
        o_res.opcode   = e_opcode;
        o_res.fin      = e_fin;
        o_res.last     = 1'b0;

        case (e_phase)
            wsd_pkg::PH_HDR1: begin
                n_fin    = i_byte[7];
                n_opcode = i_byte[3:0];
                n_phase  = (i_byte[6:4] != 3'd0) ? wsd_pkg::PH_HDR2_BAD : wsd_pkg::PH_HDR2;
            end
            wsd_pkg::PH_HDR2, wsd_pkg::PH_HDR2_BAD: begin
                if (e_phase == wsd_pkg::PH_HDR2_BAD || !i_byte[7]) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = wsd_pkg::KIND_ERROR;
                    n_phase     = wsd_pkg::PH_HALT;
                end else begin
                    n_key = '0;
                    n_pos = '0;
                    if (i_byte[6:0] <= wsd_pkg::LEN7_MAX) begin
                        n_remain = {57'd0, i_byte[6:0]};
                        n_count  = '0;
                        n_phase  = wsd_pkg::PH_MASK;
                    end else begin
                        n_remain = '0;
                        n_count  = (i_byte[6:0] == wsd_pkg::LEN7_EXT16) ?
                                   wsd_pkg::EXT16_COUNT : wsd_pkg::EXT64_COUNT;
                        n_phase  = wsd_pkg::PH_EXTLEN;
                    end
                end
            end
            wsd_pkg::PH_EXTLEN: begin
                n_remain = {e_remain[55:0], i_byte};
                if (e_count == 3'd0) begin
                    n_phase = wsd_pkg::PH_MASK;
                end else begin
                    n_count = e_count - 3'd1;
                end
            end
            wsd_pkg::PH_MASK: begin
                n_key   = {e_key[23:0], i_byte};
                n_count = cnt_inc;
                if (cnt_inc >= wsd_pkg::MASK_KEY_BYTES) begin
                    n_count = '0;
                    n_pos   = '0;
                    if (e_remain == 64'd0) begin
                        finish = 1'b1;
                    end else begin
                        n_phase = wsd_pkg::PH_PAYLOAD;
                    end
                end
            end
            wsd_pkg::PH_PAYLOAD: begin
                n_pos    = e_pos + 2'd1;
                n_remain = e_remain - 64'd1;
                if (e_remain == 64'd1) begin
                    if (control) begin
                        finish = 1'b1;
                    end else begin
                        n_phase       = wsd_pkg::PH_HDR1;
                        o_res_valid   = 1'b1;
                        o_res.payload = i_byte ^ key_byte;
                        o_res.last    = 1'b1;
                    end
                end else if (!control) begin
                    o_res_valid   = 1'b1;
                    o_res.payload = i_byte ^ key_byte;
                end
            end
            default: begin
                n_phase = wsd_pkg::PH_HALT;
            end
        endcase

        // End of a frame's payload: control frames answer here.
        if (finish) begin
            if (e_opcode == wsd_pkg::OP_CLOSE) begin
                o_res_valid = 1'b1;
                o_res.kind  = wsd_pkg::KIND_CLOSE;
                n_phase     = wsd_pkg::PH_HALT;
            end else begin
                n_phase = wsd_pkg::PH_HDR1;
                if (e_opcode == wsd_pkg::OP_PING) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = wsd_pkg::KIND_PONG;
                end
            end
        end
    end

endmodule

>>> sv/wsd_result_reg.sv
// Output register of the deframer: holds one result beat until it is taken.
// Depends on wsd_pkg for the result type.
module wsd_result_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  wsd_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_free,
    output wsd_pkg::t_result o_res
);

    logic             r_valid, n_valid;
    wsd_pkg::t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> sv/websocket_frame_deframer_core.sv
// An accepted byte goes through the input register, then the parser, into the output register.
// Throughput: one byte per cycle unless i_out_stall holds a result beat, set by the
// combinational parser update between the input register and the output register.
// Reset (i_rst_n low, synchronous): both registers empty, parser at frame
// start with length, key and position cleared.
// Top level of the websocket deframer; uses wsd_pkg, wsd_parser and wsd_result_reg.
module websocket_frame_deframer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_restart,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_payload,
    output logic [3:0] o_opcode,
    output logic       o_fin,
    output logic       o_last
);

    // The input register holds one received beat. It is handed to the parser
    // in the cycle in which the output register can take whatever the byte
    // produces, so a byte never waits on whether it turns out to yield a result.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_restart;

    logic             step;
    logic             res_valid;
    logic             out_free;
    wsd_pkg::t_result step_res;
    wsd_pkg::t_result out_res;

    assign step       = r_in_valid && out_free;
    // A new beat enters when the register is empty or drains in this cycle.
    assign o_in_stall = r_in_valid && !step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte    <= i_data_byte;
            r_in_restart <= i_restart;
        end
    end

    // Frame parser: header, extended length, mask key and payload unmasking.
    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_restart   (r_in_restart),
        .o_res_valid (res_valid),
        .o_res       (step_res)
    );

    // Output register; loads only on a step that actually yields a result.
    wsd_result_reg u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_res   (step_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_free  (out_free),
        .o_res   (out_res)
    );

    assign o_kind    = out_res.kind;
    assign o_payload = out_res.payload;
    assign o_opcode  = out_res.opcode;
    assign o_fin     = out_res.fin;
    assign o_last    = out_res.last;

endmodule

>>> sv/wsd_checker.sv
// Port-level checks for the websocket deframer, bound to the top level.
// Depends on wsd_pkg for kind and opcode codes.
module wsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_kind,
    input logic [7:0] o_payload,
    input logic [3:0] o_opcode,
    input logic       o_fin,
    input logic       o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_kind) && $stable(o_payload)
            && $stable(o_opcode) && $stable(o_fin) && $stable(o_last))
        else $error("stalled result beat changed");

    a_ctrl_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != wsd_pkg::KIND_DATA) |-> !o_last && (o_payload == 8'd0))
        else $error("non-data result carries payload or last");

    a_ctrl_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_kind != wsd_pkg::KIND_PONG) || (o_opcode == wsd_pkg::OP_PING))
            && ((o_kind != wsd_pkg::KIND_CLOSE) || (o_opcode == wsd_pkg::OP_CLOSE)))
        else $error("pong or close reported for the wrong opcode");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (.*);
